/* rtl/pctlb_pkg.sv */
// Package for the per-CPU set-associative TLB with LRU replacement.
// Holds the sizes, the function codes and the layout of one memory row.
// No dependencies; the channel interfaces and the top level import it.
package pctlb_pkg;

   localparam int NUM_CPUS  = 4;
   localparam int NUM_SETS  = 512;
   localparam int NUM_WAYS  = 4;
   localparam int PAGE_BITS = 52;

   localparam int CPU_W     = 2;
   localparam int COUNT_W   = 3;
   localparam int COUNT_MAX = 7;

   localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int RANK_W = WAY_W;

   typedef enum logic {
      FUNC_ACCESS     = 1'b0,
      FUNC_INVALIDATE = 1'b1
   } func_type;

   // One way of one CPU's TLB. Rank 0 is the most recently used.
   typedef struct packed {
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
      logic [RANK_W-1:0]    rank;
   } way_type;

   typedef way_type [NUM_WAYS-1:0] tlb_set_type;

   // A memory row holds one set of every CPU's TLB.
   typedef tlb_set_type [NUM_CPUS-1:0] row_type;

   localparam int ROW_W = $bits(row_type);

endpackage

/* rtl/pctlb_if.sv */
// Request and response channel interfaces of the per-CPU TLB block.
// Depends on pctlb_pkg for the field widths.
interface pctlb_req_if import pctlb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [CPU_W-1:0]     cpu;
   logic [PAGE_BITS-1:0] page;

   modport source (output valid, output func, output cpu, output page, input ready);
   modport sink   (input valid, input func, input cpu, input page, output ready);
endinterface

interface pctlb_rsp_if import pctlb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [COUNT_W-1:0] cleared_count;

   modport source (output valid, output hit, output cleared_count, input ready);
   modport sink   (input valid, input hit, input cleared_count, output ready);
endinterface

/* rtl/pctlb_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pctlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/per_cpu_set_assoc_tlb_lru_top.sv */
// Top level of the per-CPU set-associative TLB with LRU replacement.
// Depends on pctlb_pkg, the channel interfaces in pctlb_if and pctlb_ram.
//
//   channel  dir  fields                      meaning
//   req      in   func, cpu, page             access one CPU's TLB or invalidate everywhere
//   rsp      out  hit, cleared_count          one response per request
//
// For each request the set's row is read from the RAM as the request is taken and
// written back modified in ST_LOOKUP, so one request is in flight at a time.
// After reset a clearing pass writes every row, NUM_SETS (512) of them, with req.ready low.
// A finished response waits in an output register with one spare slot behind it, so a
// new request is taken while the previous response is still unread.
module per_cpu_set_assoc_tlb_lru_top import pctlb_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   pctlb_req_if.sink   req,
   pctlb_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type            state_ff;
   logic [SET_W-1:0]     clear_idx_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 spare_valid_ff;
   logic                 spare_hit_ff;
   logic [COUNT_W-1:0]   spare_count_ff;

   func_type             req_func_ff;
   logic [CPU_W-1:0]     req_cpu_ff;
   logic [PAGE_BITS-1:0] req_page_ff;

   logic                 req_accept;
   logic                 rsp_drain;
   logic                 ram_wr_en;
   logic [SET_W-1:0]     ram_wr_addr;
   logic [ROW_W-1:0]     ram_wr_data;
   logic [ROW_W-1:0]     ram_rd_data;

   row_type              row_rd;
   row_type              row_new;
   row_type              clear_row;
   tlb_set_type          tlb_cur;
   tlb_set_type          tlb_new;
   logic                 cpu_ok;
   logic                 hit_found;
   logic [WAY_W-1:0]     hit_way;
   logic                 free_found;
   logic [WAY_W-1:0]     victim_way;
   logic [WAY_W-1:0]     touch_way;
   logic [RANK_W-1:0]    touch_rank;
   logic                 clr_done;
   logic                 res_hit;
   logic [COUNT_W-1:0]   res_count;

   assign req.ready  = (state_ff == ST_IDLE) && !spare_valid_ff;
   assign req_accept = req.valid && req.ready;
   assign rsp_drain  = rsp_valid_ff && rsp.ready;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit           = rsp_hit_ff;
   assign rsp.cleared_count = rsp_count_ff;

   pctlb_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req.page[SET_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_LOOKUP);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clear_idx_ff : req_page_ff[SET_W-1:0];
   assign ram_wr_data = (state_ff == ST_CLEAR) ? ROW_W'(clear_row) : ROW_W'(row_new);

   // After reset every way is invalid and ranked by its way index.
   always_comb begin
      for (int c = 0; c < NUM_CPUS; c++) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            clear_row[c][w].valid = 1'b0;
            clear_row[c][w].page  = '0;
            clear_row[c][w].rank  = RANK_W'(w);
         end
      end
   end

   // Modify the row read for the request held in req_*_ff.
   always_comb begin
      row_rd     = row_type'(ram_rd_data);
      row_new    = row_rd;
      cpu_ok     = (int'(req_cpu_ff) < NUM_CPUS);
      tlb_cur    = row_rd[req_cpu_ff];
      hit_found  = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      victim_way = '0;
      res_hit    = 1'b0;
      res_count  = '0;
      clr_done   = 1'b0;

      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!hit_found && tlb_cur[w].valid && (tlb_cur[w].page == req_page_ff)) begin
            hit_found = 1'b1;
            hit_way   = WAY_W'(w);
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!free_found && !tlb_cur[w].valid) begin
            free_found = 1'b1;
            victim_way = WAY_W'(w);
         end
      end
      // With every way valid the ranks are a permutation, so the highest is unique.
      if (!free_found) begin
         for (int w = 1; w < NUM_WAYS; w++) begin
            if (tlb_cur[w].rank > tlb_cur[victim_way].rank) begin
               victim_way = WAY_W'(w);
            end
         end
      end

      touch_way  = hit_found ? hit_way : victim_way;
      touch_rank = tlb_cur[touch_way].rank;
      tlb_new    = tlb_cur;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (tlb_cur[w].rank < touch_rank) begin
            tlb_new[w].rank = tlb_cur[w].rank + RANK_W'(1);
         end
      end
      tlb_new[touch_way].rank = '0;
      if (!hit_found) begin
         tlb_new[touch_way].valid = 1'b1;
         tlb_new[touch_way].page  = req_page_ff;
      end

      if (req_func_ff == FUNC_INVALIDATE) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            clr_done = 1'b0;
            for (int w = 0; w < NUM_WAYS; w++) begin
               if (!clr_done && row_rd[c][w].valid && (row_rd[c][w].page == req_page_ff)) begin
                  row_new[c][w].valid = 1'b0;
                  clr_done            = 1'b1;
               end
            end
            if (clr_done && (res_count != COUNT_W'(COUNT_MAX))) begin
               res_count = res_count + COUNT_W'(1);
            end
         end
      end else if (cpu_ok) begin
         row_new[req_cpu_ff] = tlb_new;
         res_hit             = hit_found;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_func_ff <= func_type'(req.func);
         req_cpu_ff  <= req.cpu;
         req_page_ff <= req.page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_idx_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (clear_idx_ff == SET_W'(NUM_SETS - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  clear_idx_ff <= clear_idx_ff + SET_W'(1);
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase

         // The spare slot is empty whenever a lookup finishes, since no request
         // is taken while it is occupied.
         if (state_ff == ST_LOOKUP) begin
            if (!rsp_valid_ff || rsp_drain) begin
               rsp_valid_ff <= 1'b1;
               rsp_hit_ff   <= res_hit;
               rsp_count_ff <= res_count;
            end else begin
               spare_valid_ff <= 1'b1;
               spare_hit_ff   <= res_hit;
               spare_count_ff <= res_count;
            end
         end else if (rsp_drain) begin
            rsp_valid_ff   <= spare_valid_ff;
            rsp_hit_ff     <= spare_hit_ff;
            rsp_count_ff   <= spare_count_ff;
            spare_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_accept_writes_back: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOKUP) && ram_wr_en)
      else $error("accepted request was not followed by a row write-back");

   a_spare_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> rsp_valid_ff)
      else $error("spare response held while the output register is empty");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && (rsp_count_ff != '0)))
      else $error("response reports both a hit and cleared entries");

   a_no_request_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("request port ready during the clearing pass");
`endif

endmodule
